/* sv/masked_pose_blend_defines.svh */
// Assertion macros for the masked pose blend block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef MASKED_POSE_BLEND_DEFINES_SVH
`define MASKED_POSE_BLEND_DEFINES_SVH

// Checks that an expression holds at every clock edge out of reset.
`define MPB_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define MPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/mpb_pkg.sv */
// Shared types and constants for the masked pose blend pipeline.
// No dependencies; the front, step and top-level modules refer to it by scoped names.
package mpb_pkg;

  // Fixed-point constants.
  localparam int unsigned Q15One  = 32768;
  localparam int unsigned Q15Half = 16384;

  // Pipeline geometry.
  localparam int unsigned FrontStages = 7;
  localparam int unsigned SqSteps     = 25;
  localparam int unsigned DvSteps     = 16;

  // Datapath widths.
  localparam int unsigned RadW  = 49;  // squared length shifted up by 16
  localparam int unsigned RootW = 25;  // square root of the radicand
  localparam int unsigned NumW  = 40;  // division remainder
  localparam int unsigned QuoW  = 16;  // quotient magnitude
  localparam int unsigned MagW  = 17;  // lerped component magnitude

  // Configuration register indexes.
  typedef enum logic [0:0] {
    RegBlendAlpha = 1'b0,
    RegUseMask    = 1'b1
  } reg_idx_e;

  // Handshake control handed from a stage to the one before it.
  typedef struct packed {
    logic en;    // global advance, low while the output is stalled
    logic take;  // downstream stage loads this cycle
  } ctl_t;

  // Results that ride alongside the normalization.
  typedef struct packed {
    logic [59:0]                trans;
    logic [15:0]                scale;
    logic [3:0][MagW-1:0]       mag;
    logic [3:0]                 neg;
  } side_t;

  typedef struct packed {
    side_t                      side;
    logic [RadW-1:0]            rem;
    logic [RootW-1:0]           root;
  } sqrt_t;

  typedef struct packed {
    side_t                      side;
    logic [RootW-1:0]           root;
    logic [3:0][NumW-1:0]       rem;
    logic [3:0][QuoW-1:0]       quo;
  } div_t;

endpackage

/* sv/mpb_stream_if.sv */
// Valid/ready stream interfaces for pose requests and blended results.
// Depends on nothing; field widths are fixed by the pose format.
interface mpb_in_if;
  logic        valid;
  logic        ready;
  logic [59:0] a_translation;
  logic [63:0] a_rotation;
  logic [15:0] a_scale;
  logic [59:0] b_translation;
  logic [63:0] b_rotation;
  logic [15:0] b_scale;
  logic [15:0] mask_weight;

  modport source(output valid, a_translation, a_rotation, a_scale,
                 b_translation, b_rotation, b_scale, mask_weight,
                 input ready);
  modport sink(input valid, a_translation, a_rotation, a_scale,
               b_translation, b_rotation, b_scale, mask_weight,
               output ready);
endinterface

interface mpb_out_if;
  logic        valid;
  logic        ready;
  logic [59:0] out_translation;
  logic [63:0] out_rotation;
  logic [15:0] out_scale;

  modport source(output valid, out_translation, out_rotation, out_scale,
                 input ready);
  modport sink(input valid, out_translation, out_rotation, out_scale,
               output ready);
endinterface

/* sv/mpb_front.sv */
// Front of the blend pipeline: blend factor, lerps, dot product and squared length.
// Depends on mpb_pkg and mpb_in_if; seven register stages.
module mpb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          alpha_i,
  input  logic                 use_mask_i,
  mpb_in_if.sink               in_i,
  input  mpb_pkg::ctl_t        ctl_i,
  output logic                 valid_o,
  output mpb_pkg::sqrt_t       data_o,
  output logic [mpb_pkg::FrontStages-1:0] stage_v_o
);

  localparam int unsigned NS = mpb_pkg::FrontStages;

  logic [NS-1:0] v_q;
  logic [NS-1:0] ld;
  logic [NS-1:0] take;
  logic [NS-1:0] v_in;

  // Stage 0 registers: raw poses and blend factor.
  logic signed [19:0] s0_at_q [3];
  logic signed [19:0] s0_bt_q [3];
  logic signed [15:0] s0_ar_q [4];
  logic signed [15:0] s0_br_q [4];
  logic [15:0]        s0_sa_q, s0_sb_q, s0_t_q;
  // Stage 1: products.
  logic signed [19:0] s1_at_q [3];
  logic signed [37:0] s1_tp_q [3];
  logic [15:0]        s1_sa_q, s1_t_q;
  logic signed [33:0] s1_sp_q;
  logic signed [15:0] s1_ar_q [4];
  logic signed [15:0] s1_br_q [4];
  logic signed [31:0] s1_dp_q [4];
  // Stage 2: finished translation and scale, rotation differences.
  logic [59:0]        s2_trans_q;
  logic [15:0]        s2_scale_q, s2_t_q;
  logic signed [15:0] s2_ar_q [4];
  logic signed [17:0] s2_d_q  [4];
  // Stage 3: rotation products.
  logic [59:0]        s3_trans_q;
  logic [15:0]        s3_scale_q;
  logic signed [15:0] s3_ar_q [4];
  logic signed [35:0] s3_rp_q [4];
  // Stage 4: lerped rotation.
  logic [59:0]        s4_trans_q;
  logic [15:0]        s4_scale_q;
  logic signed [17:0] s4_c_q [4];
  // Stage 5: squares.
  mpb_pkg::side_t     s5_side_q;
  logic [30:0]        s5_sq_q [4];
  // Stage 6: radicand.
  mpb_pkg::sqrt_t     s6_q;

  // Combinational values.
  logic [15:0]        alpha_c, mask_c, t_c;
  logic [31:0]        tm_c;
  logic signed [16:0] ts0, ts2;
  logic signed [20:0] dt_c [3];
  logic signed [16:0] ds_c;
  logic signed [37:0] tp_c [3];
  logic signed [33:0] sp_c;
  logic signed [31:0] dp_c [4];
  logic signed [37:0] tl_c [3];
  logic [59:0]        trans_c;
  logic signed [33:0] sl_c;
  logic [15:0]        scale_c;
  logic signed [33:0] dot_c;
  logic signed [17:0] bsel_c [4];
  logic signed [17:0] d_c [4];
  logic signed [35:0] rp_c [4];
  logic signed [17:0] c_c [4];
  logic signed [35:0] sqf_c [4];
  mpb_pkg::side_t     side_c;
  logic [32:0]        len_c;

  // Stall control: a stage loads when the pipe advances or when it is empty.
  assign v_in = {v_q[NS-2:0], in_i.valid};
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      ld[k] = ctl_i.en || !v_q[k];
    end
    take = {ctl_i.take, ld[NS-1:1]};
  end

  assign in_i.ready = ld[0];
  assign valid_o    = v_q[NS-1];
  assign data_o     = s6_q;
  assign stage_v_o  = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_in[k];
        end else if (take[k]) begin
          v_q[k] <= 1'b0;
        end
      end
    end
  end

  // Blend factor: clamped alpha, optionally scaled by the clamped mask weight.
  always_comb begin
    alpha_c = (alpha_i > 16'(mpb_pkg::Q15One)) ? 16'(mpb_pkg::Q15One) : alpha_i;
    mask_c  = (in_i.mask_weight > 16'(mpb_pkg::Q15One)) ? 16'(mpb_pkg::Q15One)
                                                          : in_i.mask_weight;
    tm_c    = 32'(alpha_c) * 32'(mask_c);
    t_c     = use_mask_i ? 16'((tm_c + 32'(mpb_pkg::Q15Half)) >> 15) : alpha_c;
  end

  // Stage 1 products: lerp deltas times t, and the rotation dot terms.
  always_comb begin
    ts0 = $signed({1'b0, s0_t_q});
    for (int i = 0; i < 3; i++) begin
      dt_c[i] = 21'(s0_bt_q[i]) - 21'(s0_at_q[i]);
      tp_c[i] = 38'(dt_c[i]) * 38'(ts0);
    end
    ds_c = $signed({1'b0, s0_sb_q}) - $signed({1'b0, s0_sa_q});
    sp_c = 34'(ds_c) * 34'(ts0);
    for (int i = 0; i < 4; i++) begin
      dp_c[i] = 32'(s0_ar_q[i]) * 32'(s0_br_q[i]);
    end
  end

  // Stage 2: round and saturate translation and scale; pick the rotation hemisphere.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tl_c[i] = 38'(s1_at_q[i]) + ((s1_tp_q[i] + 38'sd16384) >>> 15);
      if (tl_c[i] > 38'sd524287) begin
        trans_c[20*i +: 20] = 20'h7FFFF;
      end else if (tl_c[i] < -38'sd524288) begin
        trans_c[20*i +: 20] = 20'h80000;
      end else begin
        trans_c[20*i +: 20] = tl_c[i][19:0];
      end
    end
    sl_c = 34'($signed({1'b0, s1_sa_q})) + ((s1_sp_q + 34'sd16384) >>> 15);
    if (sl_c < 34'sd0) begin
      scale_c = 16'h0000;
    end else if (sl_c > 34'sd65535) begin
      scale_c = 16'hFFFF;
    end else begin
      scale_c = sl_c[15:0];
    end
    dot_c = 34'(s1_dp_q[0]) + 34'(s1_dp_q[1]) + 34'(s1_dp_q[2]) + 34'(s1_dp_q[3]);
    for (int i = 0; i < 4; i++) begin
      bsel_c[i] = dot_c[33] ? -18'(s1_br_q[i]) : 18'(s1_br_q[i]);
      d_c[i]    = bsel_c[i] - 18'(s1_ar_q[i]);
    end
  end

  // Stages 3 to 5: rotation lerp and squared components.
  always_comb begin
    ts2 = $signed({1'b0, s2_t_q});
    for (int i = 0; i < 4; i++) begin
      rp_c[i]  = 36'(s2_d_q[i]) * 36'(ts2);
      c_c[i]   = 18'(s3_ar_q[i]) + 18'((s3_rp_q[i] + 36'sd16384) >>> 15);
      sqf_c[i] = 36'(s4_c_q[i]) * 36'(s4_c_q[i]);
    end
    side_c.trans = s4_trans_q;
    side_c.scale = s4_scale_q;
    for (int i = 0; i < 4; i++) begin
      side_c.neg[i] = s4_c_q[i][17];
      side_c.mag[i] = s4_c_q[i][17] ? 17'(-s4_c_q[i]) : 17'(s4_c_q[i]);
    end
    len_c = 33'(s5_sq_q[0]) + 33'(s5_sq_q[1]) + 33'(s5_sq_q[2]) + 33'(s5_sq_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        s0_at_q[i] <= in_i.a_translation[20*i +: 20];
        s0_bt_q[i] <= in_i.b_translation[20*i +: 20];
      end
      for (int i = 0; i < 4; i++) begin
        s0_ar_q[i] <= in_i.a_rotation[16*i +: 16];
        s0_br_q[i] <= in_i.b_rotation[16*i +: 16];
      end
      s0_sa_q <= in_i.a_scale;
      s0_sb_q <= in_i.b_scale;
      s0_t_q  <= t_c;
    end
    if (ld[1]) begin
      s1_at_q <= s0_at_q;
      s1_tp_q <= tp_c;
      s1_sa_q <= s0_sa_q;
      s1_sp_q <= sp_c;
      s1_t_q  <= s0_t_q;
      s1_ar_q <= s0_ar_q;
      s1_br_q <= s0_br_q;
      s1_dp_q <= dp_c;
    end
    if (ld[2]) begin
      s2_trans_q <= trans_c;
      s2_scale_q <= scale_c;
      s2_t_q     <= s1_t_q;
      s2_ar_q    <= s1_ar_q;
      s2_d_q     <= d_c;
    end
    if (ld[3]) begin
      s3_trans_q <= s2_trans_q;
      s3_scale_q <= s2_scale_q;
      s3_ar_q    <= s2_ar_q;
      s3_rp_q    <= rp_c;
    end
    if (ld[4]) begin
      s4_trans_q <= s3_trans_q;
      s4_scale_q <= s3_scale_q;
      s4_c_q     <= c_c;
    end
    if (ld[5]) begin
      s5_side_q <= side_c;
      for (int i = 0; i < 4; i++) begin
        s5_sq_q[i] <= sqf_c[i][30:0];
      end
    end
    if (ld[6]) begin
      s6_q.side <= s5_side_q;
      s6_q.rem  <= {len_c, 16'h0000};
      s6_q.root <= '0;
    end
  end

endmodule

/* sv/mpb_sqrt_step.sv */
// One stage of the digit-by-digit integer square root: settles one root bit.
// Depends on mpb_pkg.
module mpb_sqrt_step #(
  parameter int unsigned Bit = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mpb_pkg::ctl_t  ctl_i,
  input  logic           valid_i,
  input  mpb_pkg::sqrt_t data_i,
  output logic           take_o,
  output logic           valid_o,
  output mpb_pkg::sqrt_t data_o
);

  localparam int unsigned TW = mpb_pkg::RadW + 1;

  logic           v_q;
  mpb_pkg::sqrt_t d_q;
  mpb_pkg::sqrt_t nxt;
  logic [TW-1:0]  trial;
  logic           fits;

  assign take_o  = ctl_i.en || !v_q;
  assign valid_o = v_q;
  assign data_o  = d_q;

  // Try adding this bit to the root: the remainder drops by 2*root*2^Bit + 4^Bit.
  always_comb begin
    trial    = (TW'(data_i.root) << (Bit + 1)) + (TW'(1) << (2 * Bit));
    fits     = TW'(data_i.rem) >= trial;
    nxt      = data_i;
    if (fits) begin
      nxt.rem  = mpb_pkg::RadW'(TW'(data_i.rem) - trial);
      nxt.root = data_i.root | (mpb_pkg::RootW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (take_o) begin
      v_q <= valid_i;
    end else if (ctl_i.take) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      d_q <= nxt;
    end
  end

endmodule

/* sv/mpb_div_step.sv */
// One stage of the four-lane restoring divider: settles one quotient bit per lane.
// Depends on mpb_pkg.
module mpb_div_step #(
  parameter int unsigned Bit = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mpb_pkg::ctl_t ctl_i,
  input  logic          valid_i,
  input  mpb_pkg::div_t data_i,
  output logic          take_o,
  output logic          valid_o,
  output mpb_pkg::div_t data_o
);

  localparam int unsigned TW = mpb_pkg::NumW + 1;

  logic          v_q;
  mpb_pkg::div_t d_q;
  mpb_pkg::div_t nxt;
  logic [TW-1:0] trial;

  assign take_o  = ctl_i.en || !v_q;
  assign valid_o = v_q;
  assign data_o  = d_q;

  // Subtract the shifted divisor from each lane where it fits.
  always_comb begin
    trial = TW'(data_i.root) << Bit;
    nxt   = data_i;
    for (int i = 0; i < 4; i++) begin
      if (TW'(data_i.rem[i]) >= trial) begin
        nxt.rem[i]      = mpb_pkg::NumW'(TW'(data_i.rem[i]) - trial);
        nxt.quo[i][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (take_o) begin
      v_q <= valid_i;
    end else if (ctl_i.take) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      d_q <= nxt;
    end
  end

endmodule

/* sv/masked_pose_blend.sv */
// Top level of the masked pose blend: config registers, root and divide chains, output.
// Depends on mpb_pkg, mpb_stream_if, mpb_front, mpb_sqrt_step, mpb_div_step and the defines header.
//
//   Channel   Dir   Handshake      Moves
//   in_i      in    valid/ready    one bone: poses a and b plus mask weight
//   out_o     out   valid/ready    blended translation, rotation, scale
//   cfg_*     in    cfg_we_i only  blend_alpha (index 0), use_mask (index 1)
//
// One request enters per cycle unless the output stalls; each result passes through
// 7 front stages, a 25-stage square root, a 16-stage divider and the output register.
// The square root and the divider set the depth, one result bit per stage.
// Reset clears all valid bits and both config registers.
// A stalled output freezes full stages; empty stages keep filling, so the
// input is ready whenever the first stage is empty.
`include "masked_pose_blend_defines.svh"

module masked_pose_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  mpb_in_if.sink      in_i,
  mpb_out_if.source   out_o
);

  localparam int unsigned NSq  = mpb_pkg::SqSteps;
  localparam int unsigned NDv  = mpb_pkg::DvSteps;
  localparam int unsigned CntW = 6;

  logic [15:0] alpha_q;
  logic        use_mask_q;

  logic                  en;
  logic [NSq:0]          sq_v;
  logic [NSq:0]          sq_ld;
  mpb_pkg::sqrt_t        sq_d [NSq+1];
  logic [NDv:0]          dv_v;
  logic [NDv:0]          dv_ld;
  mpb_pkg::div_t         dv_d [NDv+1];
  logic [mpb_pkg::FrontStages-1:0] front_v;

  logic                  out_v_q;
  logic [59:0]           out_trans_q;
  logic [63:0]           out_rot_q;
  logic [15:0]           out_scale_q;
  logic [63:0]           rot_c;

  logic [CntW-1:0]       cnt_q, cnt_d;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= '0;
      use_mask_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (mpb_pkg::reg_idx_e'(cfg_idx_i))
        mpb_pkg::RegBlendAlpha: alpha_q    <= cfg_data_i;
        mpb_pkg::RegUseMask:    use_mask_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The whole pipe advances unless a finished result is waiting.
  assign en = out_o.ready || !out_v_q;

  mpb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .alpha_i    (alpha_q),
    .use_mask_i (use_mask_q),
    .in_i       (in_i),
    .ctl_i      ('{en: en, take: sq_ld[0]}),
    .valid_o    (sq_v[0]),
    .data_o     (sq_d[0]),
    .stage_v_o  (front_v)
  );

  // Square root chain, most significant root bit first.
  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    mpb_sqrt_step #(.Bit(NSq - 1 - k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   ('{en: en, take: sq_ld[k+1]}),
      .valid_i (sq_v[k]),
      .data_i  (sq_d[k]),
      .take_o  (sq_ld[k]),
      .valid_o (sq_v[k+1]),
      .data_o  (sq_d[k+1])
    );
  end
  assign sq_ld[NSq] = dv_ld[0];

  // Divider setup: numerator is |c| * 2^22 plus half the root for rounding.
  assign dv_v[0] = sq_v[NSq];
  always_comb begin
    dv_d[0].side    = sq_d[NSq].side;
    dv_d[0].root    = sq_d[NSq].root;
    dv_d[0].quo     = '0;
    for (int i = 0; i < 4; i++) begin
      dv_d[0].rem[i] = {1'b0, sq_d[NSq].side.mag[i], 22'h000000}
                     + mpb_pkg::NumW'(sq_d[NSq].root >> 1);
    end
  end

  for (genvar k = 0; k < NDv; k++) begin : g_div
    mpb_div_step #(.Bit(NDv - 1 - k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   ('{en: en, take: dv_ld[k+1]}),
      .valid_i (dv_v[k]),
      .data_i  (dv_d[k]),
      .take_o  (dv_ld[k]),
      .valid_o (dv_v[k+1]),
      .data_o  (dv_d[k+1])
    );
  end
  assign dv_ld[NDv] = en;

  // Output stage: restore signs, saturate, zero rotation for a zero length.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dv_d[NDv].root == '0) begin
        rot_c[16*i +: 16] = 16'h0000;
      end else if (dv_d[NDv].side.neg[i]) begin
        rot_c[16*i +: 16] = (dv_d[NDv].quo[i] > 16'h8000) ? 16'h8000
                                                          : 16'(-dv_d[NDv].quo[i]);
      end else begin
        rot_c[16*i +: 16] = (dv_d[NDv].quo[i] > 16'h7FFF) ? 16'h7FFF
                                                          : dv_d[NDv].quo[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v[NDv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_trans_q <= dv_d[NDv].side.trans;
      out_rot_q   <= rot_c;
      out_scale_q <= dv_d[NDv].side.scale;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.out_translation = out_trans_q;
  assign out_o.out_rotation    = out_rot_q;
  assign out_o.out_scale       = out_scale_q;

  // Requests in flight, for checking that the pipe neither drops nor duplicates.
  always_comb begin
    cnt_d = cnt_q;
    if (in_i.valid && in_i.ready) begin
      cnt_d = cnt_d + CntW'(1);
    end
    if (out_o.valid && out_o.ready) begin
      cnt_d = cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `MPB_ASSERT_ALWAYS(a_occupancy, int'(cnt_q) == $countones(front_v) + $countones(sq_v[NSq:1]) + $countones(dv_v[NDv:1]) + $countones(out_v_q), "valid bits disagree with requests in flight")
  `MPB_ASSERT_NEXT(a_zero_len, en && dv_v[NDv] && dv_d[NDv].root == '0, out_o.out_rotation == 64'h0, "zero length did not give a zero rotation")

endmodule
